// ===== design/crcj_pkg.sv =====
// Package for the word-wide reflected CRC-64 (Jones polynomial).
// Holds item structs, polynomial constant and the per-lane column functions.
// No dependencies.
package crcj_pkg;

  localparam int unsigned CrcWidth  = 64;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned NumLanes  = CrcWidth / ByteWidth;

  localparam logic [CrcWidth-1:0] CrcPoly = 64'h95AC9329AC4BC9B5;

  typedef struct packed {
    logic [CrcWidth-1:0] data_word;
    logic                first_word;
    logic                last_word;
  } in_item_t;

  typedef struct packed {
    logic [CrcWidth-1:0] crc_value;
    logic                is_final;
  } out_item_t;

  typedef logic [ByteWidth-1:0][CrcWidth-1:0] lane_mat_t;

  // Advance a one-hot remainder through one full word; elaboration only.
  function automatic logic [CrcWidth-1:0] col_mask(int unsigned bit_pos);
    logic [CrcWidth-1:0] r;
    r = '0;
    r[bit_pos] = 1'b1;
    for (int unsigned i = 0; i < CrcWidth; i++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic lane_mat_t lane_matrix(int unsigned lane);
    lane_mat_t m;
    for (int unsigned i = 0; i < ByteWidth; i++) begin
      m[i] = col_mask(lane * ByteWidth + i);
    end
    return m;
  endfunction

endpackage

// ===== design/crcj_lane.sv =====
// One byte lane: contribution of one byte of the folded word to the next
// remainder, as a fixed XOR network. Depends on crcj_pkg.
module crcj_lane #(
  parameter int unsigned LaneIdx = 0
) (
  input  logic [crcj_pkg::ByteWidth-1:0] byte_i,
  output logic [crcj_pkg::CrcWidth-1:0]  part_o
);

  localparam crcj_pkg::lane_mat_t Cols = crcj_pkg::lane_matrix(LaneIdx);

  always_comb begin
    part_o = '0;
    for (int unsigned i = 0; i < crcj_pkg::ByteWidth; i++) begin
      if (byte_i[i]) begin
        part_o = part_o ^ Cols[i];
      end
    end
  end

endmodule

// ===== design/crcj_core.sv =====
// Remainder register, seed register, byte lanes and the merging XOR.
// Depends on crcj_pkg and crcj_lane.
module crcj_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [crcj_pkg::CrcWidth-1:0] cfg_seed_i,
  input  logic                         step_i,
  input  crcj_pkg::in_item_t           item_i,
  output crcj_pkg::out_item_t          result_o
);

  logic [crcj_pkg::CrcWidth-1:0] seed_q, seed_d;
  logic [crcj_pkg::CrcWidth-1:0] rem_q, rem_d;
  logic [crcj_pkg::CrcWidth-1:0] folded;
  logic [crcj_pkg::CrcWidth-1:0] merged;
  logic [crcj_pkg::NumLanes-1:0][crcj_pkg::CrcWidth-1:0] parts;

  assign folded = (item_i.first_word ? ~seed_q : rem_q) ^ item_i.data_word;

  for (genvar g = 0; g < crcj_pkg::NumLanes; g++) begin : g_lane
    crcj_lane #(
      .LaneIdx(g)
    ) u_lane (
      .byte_i(folded[g*crcj_pkg::ByteWidth +: crcj_pkg::ByteWidth]),
      .part_o(parts[g])
    );
  end

  always_comb begin
    merged = '0;
    for (int unsigned k = 0; k < crcj_pkg::NumLanes; k++) begin
      merged = merged ^ parts[k];
    end
  end

  assign rem_d  = step_i ? merged : rem_q;
  assign seed_d = cfg_we_i ? cfg_seed_i : seed_q;

  assign result_o.crc_value = ~merged;
  assign result_o.is_final  = item_i.last_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '1;
      seed_q <= '0;
    end else begin
      rem_q  <= rem_d;
      seed_q <= seed_d;
    end
  end

endmodule

// ===== design/crcj_out_buf.sv =====
// Two-entry result buffer that decouples the core from the output channel.
// Depends on crcj_pkg.
module crcj_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  crcj_pkg::out_item_t item_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                ready_i,
  output crcj_pkg::out_item_t item_o
);

  crcj_pkg::out_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign pop     = valid_o && ready_i;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== design/crc64_word_slicing.sv =====
// Top level of the word-wide reflected CRC-64 (Jones polynomial).
// Depends on crcj_pkg, crcj_core and crcj_out_buf.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_ready_o   in_data_i  (crcj_pkg::in_item_t)
//   out      source     out_valid_o/out_ready_i out_data_o (crcj_pkg::out_item_t)
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_data_i (seed, 64 bits)
//
// One item per cycle unless input stalls: eight byte lanes and one XOR merge fold
// a word into the remainder in the cycle it is accepted, and push its result.
// Reset sets the remainder to all ones and the seed to zero; cfg is always ready.
// A two-entry result buffer keeps input accepted while one result waits;
// input stalls only when both entries are held.
module crc64_word_slicing (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  crcj_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output crcj_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [crcj_pkg::CrcWidth-1:0] cfg_data_i
);

  logic                buf_full;
  logic                step;
  crcj_pkg::out_item_t result;

  assign in_ready_o  = !buf_full;
  assign step        = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  crcj_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_valid_i && cfg_ready_o),
    .cfg_seed_i(cfg_data_i),
    .step_i    (step),
    .item_i    (in_data_i),
    .result_o  (result)
  );

  crcj_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (step),
    .item_i (result),
    .full_o (buf_full),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .item_o (out_data_o)
  );

endmodule
